// ===== design/trb_pkg.sv =====
// Shared types and codes for the timestamp reorder buffer.
// Used by trb_ctrl, trb_dpath and timestamp_reorder_buffer_unit; depends on nothing.
package trb_pkg;

	localparam int STAMP_W  = 64;
	localparam int HANDLE_W = 32;
	localparam int COUNT_W  = 32;
	localparam int DEPTH_W  = 6;

	localparam logic [DEPTH_W-1:0] HOLD_DEPTH_RST = DEPTH_W'(16);

	// Result codes of one input word.
	typedef enum logic [1:0] {
		OUT_HELD = 2'd0,
		OUT_EMIT = 2'd1,
		OUT_LATE = 2'd2,
		OUT_DUP  = 2'd3
	} trb_outcome_t;

	typedef struct packed {
		logic [STAMP_W-1:0]  block_stamp;
		logic [HANDLE_W-1:0] block_handle;
	} trb_in_t;

	typedef struct packed {
		trb_outcome_t        outcome;
		logic [STAMP_W-1:0]  emitted_stamp;
		logic [HANDLE_W-1:0] emitted_handle;
		logic [COUNT_W-1:0]  reject_total;
	} trb_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic late_upd;
		logic scan_clr;
		logic scan_rd;
		logic commit;
		logic out_load;
	} trb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic late;
		logic scan_last;
	} trb_status_t;

endpackage

// ===== design/trb_ctrl.sv =====
// Sequencing controller of the timestamp reorder buffer.
// Depends on trb_pkg for the command and status structs.
module trb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  trb_pkg::trb_status_t status,
	output trb_pkg::trb_cmd_t    cmd
);
	import trb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_OUTPUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// A new word is taken only while no item is in flight.
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Command decode from the current state.
	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.late_upd = (state_q == ST_CHECK) && status.late;
		cmd.scan_clr = (state_q == ST_CHECK) && !status.late;
		cmd.scan_rd  = (state_q == ST_SCAN);
		cmd.commit   = (state_q == ST_COMMIT);
		cmd.out_load = (state_q == ST_OUTPUT) && out_free;
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= status.late ? ST_OUTPUT : ST_SCAN;
				end
				ST_SCAN: begin
					if (status.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_OUTPUT;
				end
				ST_OUTPUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/trb_dpath.sv =====
// Datapath of the timestamp reorder buffer: slot memories, scan trackers, result registers.
// Depends on trb_pkg for payload types, command and status structs and result codes.
module trb_dpath #(
	parameter int CAPACITY = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  trb_pkg::trb_in_t               in_data,
	input  logic                           cfg_wr_en,
	input  logic [trb_pkg::DEPTH_W-1:0]    cfg_wr_data,
	input  trb_pkg::trb_cmd_t              cmd,
	output trb_pkg::trb_status_t           status,
	output trb_pkg::trb_out_t              out_data
);
	import trb_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int EW    = (OCC_W > DEPTH_W + 1) ? OCC_W : DEPTH_W + 1;
	localparam logic [EW-1:0]    CAP_M1   = EW'(CAPACITY - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	// Slot memories.
	logic [STAMP_W-1:0]  stamp_mem  [CAPACITY];
	logic [HANDLE_W-1:0] handle_mem [CAPACITY];

	// Architectural state.
	logic [CAPACITY-1:0] used_q;
	logic [STAMP_W-1:0]  last_q;
	logic [OCC_W-1:0]    occ_q;
	logic [COUNT_W-1:0]  late_q;
	logic [DEPTH_W-1:0]  hold_depth_q;

	// Captured input word.
	logic [STAMP_W-1:0]  stamp_q;
	logic [HANDLE_W-1:0] handle_q;

	// Scan address and read pipeline.
	logic [IDX_W-1:0]    addr_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [STAMP_W-1:0]  rd_stamp_s1;
	logic [HANDLE_W-1:0] rd_handle_s1;

	// Scan trackers.
	logic                hit_vld_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic                free_vld_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                min_vld_q;
	logic [IDX_W-1:0]    min_idx_q;
	logic [STAMP_W-1:0]  min_stamp_q;
	logic [HANDLE_W-1:0] min_handle_q;

	// Result of the current word.
	trb_outcome_t        res_outcome_q;
	logic [STAMP_W-1:0]  res_stamp_q;
	logic [HANDLE_W-1:0] res_handle_q;
	trb_out_t            out_q;

	// Commit decisions.
	logic                rd_used;
	logic [EW-1:0]       dep_raw;
	logic [EW-1:0]       eff_depth;
	logic [EW-1:0]       occ_sum;
	logic                insert;
	logic                new_is_min;
	logic                has_min;
	logic                over;
	logic                release_blk;
	logic                emit_new;
	logic                store_new;
	logic [STAMP_W-1:0]  em_stamp;
	logic [HANDLE_W-1:0] em_handle;

	assign status.late      = (stamp_q < last_q);
	assign status.scan_last = (addr_q == LAST_IDX);
	assign out_data         = out_q;
	assign rd_used          = used_q[idx_s1];

	// Depth clamped to one at the low end and to one below the store size at the top.
	assign dep_raw   = EW'(hold_depth_q);
	assign eff_depth = (dep_raw == '0) ? EW'(1) : ((dep_raw > CAP_M1) ? CAP_M1 : dep_raw);

	// The new word is stored only when no duplicate was found; it may itself be the oldest.
	assign insert      = !hit_vld_q && free_vld_q;
	assign new_is_min  = insert && (!min_vld_q || (stamp_q < min_stamp_q));
	assign has_min     = min_vld_q || insert;
	assign occ_sum     = EW'(occ_q) + EW'(insert);
	assign over        = (occ_sum > eff_depth);
	assign release_blk = over && has_min;
	assign emit_new    = release_blk && new_is_min;
	assign store_new   = insert && !emit_new;
	assign em_stamp    = emit_new ? stamp_q : min_stamp_q;

	// A replaced duplicate that is also the oldest leaves with its new handle.
	always_comb begin
		if (emit_new) begin
			em_handle = handle_q;
		end else if (hit_vld_q && (hit_idx_q == min_idx_q)) begin
			em_handle = handle_q;
		end else begin
			em_handle = min_handle_q;
		end
	end

	// Stamp memory: written on insert, read during the scan.
	always_ff @(posedge clk) begin
		if (cmd.commit && store_new) begin
			stamp_mem[free_idx_q] <= stamp_q;
		end
		if (cmd.scan_rd) begin
			rd_stamp_s1 <= stamp_mem[addr_q];
		end
	end

	// Handle memory: written on insert or duplicate replace, read during the scan.
	always_ff @(posedge clk) begin
		if (cmd.commit && hit_vld_q) begin
			handle_mem[hit_idx_q] <= handle_q;
		end else if (cmd.commit && store_new) begin
			handle_mem[free_idx_q] <= handle_q;
		end
		if (cmd.scan_rd) begin
			rd_handle_s1 <= handle_mem[addr_q];
		end
	end

	// Payload registers: captured word, scan index, trackers' values and results.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			stamp_q  <= in_data.block_stamp;
			handle_q <= in_data.block_handle;
		end
		if (cmd.scan_rd) begin
			idx_s1 <= addr_q;
		end
		if (vld_s1) begin
			if (rd_used) begin
				if ((rd_stamp_s1 == stamp_q) && !hit_vld_q) begin
					hit_idx_q <= idx_s1;
				end
				if (!min_vld_q || (rd_stamp_s1 < min_stamp_q)) begin
					min_idx_q    <= idx_s1;
					min_stamp_q  <= rd_stamp_s1;
					min_handle_q <= rd_handle_s1;
				end
			end else if (!free_vld_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (cmd.late_upd) begin
			res_outcome_q <= OUT_LATE;
			res_stamp_q   <= '0;
			res_handle_q  <= '0;
		end else if (cmd.commit) begin
			if (release_blk) begin
				res_outcome_q <= OUT_EMIT;
				res_stamp_q   <= em_stamp;
				res_handle_q  <= em_handle;
			end else begin
				res_outcome_q <= hit_vld_q ? OUT_DUP : OUT_HELD;
				res_stamp_q   <= '0;
				res_handle_q  <= '0;
			end
		end
		if (cmd.out_load) begin
			out_q.outcome        <= res_outcome_q;
			out_q.emitted_stamp  <= res_stamp_q;
			out_q.emitted_handle <= res_handle_q;
			out_q.reject_total   <= late_q;
		end
	end

	// Control state: store bookkeeping, counters, scan flags and the depth register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			last_q       <= '0;
			occ_q        <= '0;
			late_q       <= '0;
			hold_depth_q <= HOLD_DEPTH_RST;
			addr_q       <= '0;
			vld_s1       <= 1'b0;
			hit_vld_q    <= 1'b0;
			free_vld_q   <= 1'b0;
			min_vld_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				hold_depth_q <= cfg_wr_data;
			end
			vld_s1 <= cmd.scan_rd;
			if (cmd.scan_clr) begin
				addr_q     <= '0;
				hit_vld_q  <= 1'b0;
				free_vld_q <= 1'b0;
				min_vld_q  <= 1'b0;
			end else if (cmd.scan_rd) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			if (vld_s1) begin
				if (rd_used) begin
					if (rd_stamp_s1 == stamp_q) begin
						hit_vld_q <= 1'b1;
					end
					min_vld_q <= 1'b1;
				end else begin
					free_vld_q <= 1'b1;
				end
			end
			if (cmd.late_upd && (late_q != '1)) begin
				late_q <= late_q + COUNT_W'(1);
			end
			if (cmd.commit) begin
				if (store_new) begin
					used_q[free_idx_q] <= 1'b1;
				end
				if (release_blk && !emit_new) begin
					used_q[min_idx_q] <= 1'b0;
				end
				if (release_blk) begin
					last_q <= em_stamp;
				end
				if (store_new && !release_blk) begin
					occ_q <= occ_q + OCC_W'(1);
				end else if (!store_new && release_blk && !emit_new) begin
					occ_q <= occ_q - OCC_W'(1);
				end
			end
		end
	end

	// The held count always matches the slot flags.
	a_occ_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == 32'(occ_q))
		else $error("occupancy does not match the number of used slots");

	// The store never fills up, so a free slot exists for every new stamp.
	a_occ_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) < CAPACITY)
		else $error("occupancy reached the store size");

	// An insert lands only in a slot that the scan saw free.
	a_insert_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && insert) |-> !used_q[free_idx_q])
		else $error("insert into a used slot");

	// Whenever the depth is exceeded there is a block to release.
	a_release_has_block: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && over) |-> has_min)
		else $error("depth exceeded with nothing to release");

endmodule

// ===== design/timestamp_reorder_buffer_unit.sv =====
// Top level of the timestamp reorder buffer: controller plus datapath.
// Depends on trb_pkg, trb_ctrl and trb_dpath.
//
//  Channel  | Handshake            | Word
//  ---------+----------------------+--------------------------------------------------
//  in       | in_valid / in_stall  | trb_in_t: block_stamp, block_handle
//  out      | out_valid / out_stall| trb_out_t: outcome, emitted_stamp, emitted_handle,
//           |                      |            reject_total
//  cfg      | cfg_wr_en            | cfg_wr_data: hold_depth
//
// An accepted word walks the slot memory one entry per cycle through its single read
// port, then passes drain, commit and output before the next accept; a late word goes
// from check to output. Reset clears the slot flags and counters and sets the depth to
// 16 at once, with no clearing pass. The result sits in an output register: a stall on
// the out side holds only the word that follows, never the one already delivered.
module timestamp_reorder_buffer_unit #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  trb_pkg::trb_in_t            in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output trb_pkg::trb_out_t           out_data,
	input  logic                        cfg_wr_en,
	input  logic [trb_pkg::DEPTH_W-1:0] cfg_wr_data
);
	import trb_pkg::*;

	trb_cmd_t    cmd;
	trb_status_t status;

	// Sequencer for check, scan, commit and output.
	trb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Slot store, trackers and result registers.
	trb_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.out_data    (out_data)
	);

endmodule
